// ===== rtl/u8d_pkg.sv =====
`timescale 1ns / 1ps

package u8d_pkg;

  // field widths
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned CP_W   = 21;
  localparam int unsigned REP_W  = 3;

  // default depth of the job queue between front and back
  localparam int unsigned QUEUE_DEPTH_DEF = 4;

  // reset value of the replacement code register
  localparam logic [CP_W-1:0] REPLACEMENT_RST = 21'h00FFFD;

  // value limits
  localparam logic [CP_W-1:0] SURR_LO    = 21'h00D800;
  localparam logic [CP_W-1:0] SURR_HI    = 21'h00DFFF;
  localparam logic [CP_W-1:0] CP_MAX     = 21'h10FFFF;
  localparam logic [CP_W-1:0] MIN_LEN2   = 21'h000080;
  localparam logic [CP_W-1:0] MIN_LEN3   = 21'h000800;
  localparam logic [CP_W-1:0] MIN_LEN4   = 21'h010000;

  // sequence lengths
  localparam logic [2:0] LEN_NONE = 3'd0;
  localparam logic [2:0] LEN_TWO  = 3'd2;
  localparam logic [2:0] LEN_THREE = 3'd3;
  localparam logic [2:0] LEN_FOUR = 3'd4;

  // one job: a run of replacements, then an optional decoded value
  typedef struct packed {
    logic [REP_W-1:0] rep_cnt;
    logic             has_cp;
    logic [CP_W-1:0]  cp;
  } u8d_job_t;

endpackage

// ===== rtl/u8d_ifs.sv =====
`timescale 1ns / 1ps

// byte input channel
interface u8d_byte_if import u8d_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] text_byte;
  modport source (output valid, output text_byte, input ready);
  modport sink   (input valid, input text_byte, output ready);
endinterface

// decoded result channel
interface u8d_cp_if import u8d_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [CP_W-1:0] code_point;
  logic            is_error;
  logic            last_of_run;
  modport source (output valid, output code_point, output is_error, output last_of_run,
                  input ready);
  modport sink   (input valid, input code_point, input is_error, input last_of_run,
                  output ready);
endinterface

// replacement code write channel
interface u8d_cfg_if import u8d_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [CP_W-1:0] replacement_code;
  modport source (output valid, output replacement_code, input ready);
  modport sink   (input valid, input replacement_code, output ready);
endinterface

// ===== rtl/utf8_stream_decoder_unit.sv =====
`timescale 1ns / 1ps

// channel    | dir | payload                                  | word moves when
// in_word    | in  | text_byte[7:0]                           | valid && ready
// out_word   | out | code_point[20:0], is_error, last_of_run  | valid && ready
// cfg_word   | in  | replacement_code[20:0]                   | valid && ready
//
// one byte per cycle enters the front while the job queue has room; one result per
// cycle leaves the back register while jobs wait and out_word is ready; the front
// classifies a byte and the queue is written at the edge that takes it, then the
// output register takes its first result; a byte with several results holds the back
// until all have left; input stalls only once the job queue (QUEUE_DEPTH jobs) is full
// rst_n is synchronous: no sequence pending, empty queue, replacement code FFFD

module utf8_stream_decoder_unit import u8d_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  u8d_byte_if.sink  in_word,
  u8d_cp_if.source  out_word,
  u8d_cfg_if.sink   cfg_word
);

  u8d_job_t push_job, head_job;
  logic     push_valid, push_ready;
  logic     head_valid, head_pop;

  // byte classification and sequence state
  u8d_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_word   (in_word),
    .job       (push_job),
    .job_valid (push_valid),
    .job_ready (push_ready)
  );

  // job queue
  u8d_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_job   (push_job),
    .pop_valid  (head_valid),
    .pop_ready  (head_pop),
    .pop_job    (head_job)
  );

  // result expansion
  u8d_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_word   (cfg_word),
    .head_valid (head_valid),
    .head       (head_job),
    .head_pop   (head_pop),
    .out_word   (out_word)
  );

endmodule

// ===== rtl/u8d_front.sv =====
`timescale 1ns / 1ps

module u8d_front import u8d_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  u8d_byte_if.sink   in_word,
  output u8d_job_t   job,
  output logic       job_valid,
  input  logic       job_ready
);

  logic [2:0]      exp_len_r, exp_len_nxt;
  logic [2:0]      taken_r, taken_nxt;
  logic [CP_W-1:0] part_r, part_nxt;

  logic            acc;
  logic [7:0]      b;
  logic            is_cont;
  logic [CP_W-1:0] joined;
  logic [2:0]      taken_inc;
  logic            bad;
  u8d_job_t        job_c;

  assign b             = in_word.text_byte;
  assign in_word.ready = job_ready;
  assign acc           = in_word.valid && job_ready;
  assign is_cont       = (b[7:6] == 2'b10);
  assign joined        = {part_r[CP_W-7:0], b[5:0]};
  assign taken_inc     = taken_r + 3'd1;

  // value checks on a finished sequence
  always_comb begin
    bad = ((exp_len_r == LEN_TWO)   && (joined < MIN_LEN2)) ||
          ((exp_len_r == LEN_THREE) && (joined < MIN_LEN3)) ||
          ((exp_len_r == LEN_FOUR)  && (joined < MIN_LEN4)) ||
          ((joined >= SURR_LO) && (joined <= SURR_HI)) ||
          (joined > CP_MAX);
  end

  // classify the byte and build the job
  always_comb begin
    exp_len_nxt = exp_len_r;
    taken_nxt   = taken_r;
    part_nxt    = part_r;
    job_c       = '0;
    if ((exp_len_r != LEN_NONE) && is_cont) begin
      // continuation of the pending sequence
      if (taken_inc >= exp_len_r) begin
        if (bad) begin
          job_c.rep_cnt = exp_len_r;
        end else begin
          job_c.has_cp = 1'b1;
          job_c.cp     = joined;
        end
        exp_len_nxt = LEN_NONE;
        taken_nxt   = 3'd0;
        part_nxt    = '0;
      end else begin
        taken_nxt = taken_inc;
        part_nxt  = joined;
      end
    end else begin
      // a pending sequence cut short gives one replacement first
      if (exp_len_r != LEN_NONE) begin
        job_c.rep_cnt = 3'd1;
      end
      exp_len_nxt = LEN_NONE;
      taken_nxt   = 3'd0;
      part_nxt    = '0;
      priority if (b == 8'h00) begin
        // end of text
      end else if (b[7] == 1'b0) begin
        job_c.has_cp = 1'b1;
        job_c.cp     = {{(CP_W-8){1'b0}}, b};
      end else if (b[7:5] == 3'b110) begin
        exp_len_nxt = LEN_TWO;
        taken_nxt   = 3'd1;
        part_nxt    = {{(CP_W-5){1'b0}}, b[4:0]};
      end else if (b[7:4] == 4'b1110) begin
        exp_len_nxt = LEN_THREE;
        taken_nxt   = 3'd1;
        part_nxt    = {{(CP_W-4){1'b0}}, b[3:0]};
      end else if (b[7:3] == 5'b11110) begin
        exp_len_nxt = LEN_FOUR;
        taken_nxt   = 3'd1;
        part_nxt    = {{(CP_W-3){1'b0}}, b[2:0]};
      end else begin
        // stray continuation or F8..FF
        job_c.rep_cnt = job_c.rep_cnt + 3'd1;
      end
    end
  end

  assign job       = job_c;
  assign job_valid = acc && ((job_c.rep_cnt != 3'd0) || job_c.has_cp);

  // sequence state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_len_r <= LEN_NONE;
      taken_r   <= 3'd0;
      part_r    <= '0;
    end else if (acc) begin
      exp_len_r <= exp_len_nxt;
      taken_r   <= taken_nxt;
      part_r    <= part_nxt;
    end
  end

endmodule

// ===== rtl/u8d_queue.sv =====
`timescale 1ns / 1ps

module u8d_queue import u8d_pkg::*; #(
  parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push_valid,
  output logic     push_ready,
  input  u8d_job_t push_job,
  output logic     pop_valid,
  input  logic     pop_ready,
  output u8d_job_t pop_job
);

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  u8d_job_t         mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;
  logic             push, pop;

  assign push_ready = (cnt_r != CNT_FULL);
  assign pop_valid  = (cnt_r != '0);
  assign pop_job    = mem_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end else if (pop && !push) begin
        cnt_r <= cnt_r - CNT_W'(1);
      end
    end
  end

endmodule

// ===== rtl/u8d_back.sv =====
`timescale 1ns / 1ps

module u8d_back import u8d_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  u8d_cfg_if.sink  cfg_word,
  input  logic     head_valid,
  input  u8d_job_t head,
  output logic     head_pop,
  u8d_cp_if.source out_word
);

  logic [CP_W-1:0] rep_code_r;
  logic [1:0]      done_r;
  logic            out_valid_r;
  logic [CP_W-1:0] out_cp_r;
  logic            out_err_r;
  logic            out_last_r;

  logic            emit;
  logic [2:0]      done_inc;
  logic            is_rep;
  logic            rep_last;

  assign cfg_word.ready = 1'b1;

  assign emit     = head_valid && (!out_valid_r || out_word.ready);
  assign done_inc = {1'b0, done_r} + 3'd1;
  assign is_rep   = ({1'b0, done_r} < head.rep_cnt);
  assign rep_last = (done_inc == head.rep_cnt);
  assign head_pop = emit && (!is_rep || (rep_last && !head.has_cp));

  // replacement code register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rep_code_r <= REPLACEMENT_RST;
    end else if (cfg_word.valid) begin
      rep_code_r <= cfg_word.replacement_code;
    end
  end

  // replacements emitted so far for the head job
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_r <= 2'd0;
    end else if (head_pop) begin
      done_r <= 2'd0;
    end else if (emit) begin
      done_r <= done_inc[1:0];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_word.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_cp_r   <= is_rep ? rep_code_r : head.cp;
      out_err_r  <= is_rep;
      out_last_r <= is_rep ? (rep_last && !head.has_cp) : 1'b1;
    end
  end

  assign out_word.valid       = out_valid_r;
  assign out_word.code_point  = out_cp_r;
  assign out_word.is_error    = out_err_r;
  assign out_word.last_of_run = out_last_r;

endmodule

// ===== dv/utf8_stream_decoder_unit_tb.sv =====
`timescale 1ns / 1ps

module utf8_stream_decoder_unit_tb;
  import u8d_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned BYTES_PER_PHASE = 90;
  localparam int unsigned SETTLE_CYCLES = 12;

  // one decoded result as seen on the output channel
  typedef struct packed {
    logic [CP_W-1:0] code_point;
    logic            is_error;
    logic            last_of_run;
  } cp_word_t;

  // predicts decoded words from accepted bytes and checks the output stream
  class code_point_board;
    logic [CP_W-1:0] repl_code;
    logic [2:0]      seq_len;
    logic [2:0]      seq_got;
    logic [CP_W-1:0] seq_bits;
    cp_word_t        expected_cps[$];
    int unsigned     errors;

    function new();
      repl_code = REPLACEMENT_RST;
      seq_len   = LEN_NONE;
      seq_got   = 3'd0;
      seq_bits  = '0;
      errors    = 0;
    endfunction

    function void set_replacement(input logic [CP_W-1:0] code);
      repl_code = code;
    endfunction

    function void push_word(input logic [CP_W-1:0] cp, input logic err);
      cp_word_t w;
      w.code_point  = cp;
      w.is_error    = err;
      w.last_of_run = 1'b0;
      expected_cps.insert(expected_cps.size(), w);
    endfunction

    function void drop_sequence();
      seq_len  = LEN_NONE;
      seq_got  = 3'd0;
      seq_bits = '0;
    endfunction

    // decode one accepted byte into zero or more expected words
    function void take_byte(input logic [7:0] b);
      int unsigned     base;
      logic [CP_W-1:0] val;
      logic            bad;
      base = expected_cps.size();
      if (seq_len != LEN_NONE && b[7:6] == 2'b10) begin
        // continuation of the pending sequence
        seq_bits = {seq_bits[CP_W-7:0], b[5:0]};
        seq_got  = seq_got + 3'd1;
        if (seq_got >= seq_len) begin
          val = seq_bits;
          bad = (seq_len == LEN_TWO && val < MIN_LEN2) ||
                (seq_len == LEN_THREE && val < MIN_LEN3) ||
                (seq_len == LEN_FOUR && val < MIN_LEN4) ||
                (val >= SURR_LO && val <= SURR_HI) || val > CP_MAX;
          if (bad) begin
            repeat (seq_len) push_word(repl_code, 1'b1);
          end else begin
            push_word(val, 1'b0);
          end
          drop_sequence();
        end
      end else begin
        // cut-short sequence, then the byte acts as a new lead
        if (seq_len != LEN_NONE) begin
          push_word(repl_code, 1'b1);
          drop_sequence();
        end
        if (b == 8'h00) begin
          // end of text
        end else if (b[7] == 1'b0) begin
          push_word({13'd0, b}, 1'b0);
        end else if (b[7:5] == 3'b110) begin
          seq_len  = LEN_TWO;
          seq_got  = 3'd1;
          seq_bits = {16'd0, b[4:0]};
        end else if (b[7:4] == 4'b1110) begin
          seq_len  = LEN_THREE;
          seq_got  = 3'd1;
          seq_bits = {17'd0, b[3:0]};
        end else if (b[7:3] == 5'b11110) begin
          seq_len  = LEN_FOUR;
          seq_got  = 3'd1;
          seq_bits = {18'd0, b[2:0]};
        end else begin
          // stray continuation or F8..FF
          push_word(repl_code, 1'b1);
        end
      end
      if (expected_cps.size() > base)
        expected_cps[expected_cps.size()-1].last_of_run = 1'b1;
    endfunction

    // compare one output word with the oldest expectation
    function void check_word(input logic [CP_W-1:0] cp, input logic err, input logic last);
      cp_word_t want;
      if (expected_cps.size() == 0) begin
        $error("code_point %h arrived with no word pending", cp);
        errors++;
        return;
      end
      want = expected_cps.pop_front();
      if (cp !== want.code_point) begin
        $error("code_point expected %h actual %h", want.code_point, cp);
        errors++;
      end
      if (err !== want.is_error) begin
        $error("is_error expected %b actual %b", want.is_error, err);
        errors++;
      end
      if (last !== want.last_of_run) begin
        $error("last_of_run expected %b actual %b", want.last_of_run, last);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;

  u8d_byte_if in_if ();
  u8d_cp_if   out_if ();
  u8d_cfg_if  cfg_if ();

  code_point_board board;
  int unsigned     in_gap_max;
  int unsigned     out_gap_max;
  int unsigned     bytes_sent;
  int unsigned     cycle_count;

  logic [7:0] directed_bytes[$] = '{
    8'h41, 8'h7F,                      // ascii
    8'hC2, 8'h80,                      // smallest two-byte value
    8'hF4, 8'h8F, 8'hBF, 8'hBF,        // largest scalar value
    8'h80,                             // stray continuation
    8'hFF,                             // invalid lead
    8'hC3, 8'h41,                      // cut short by ascii
    8'hC3, 8'hE2, 8'h82, 8'hAC,        // cut short by a new lead
    8'hE2, 8'h00,                      // zero inside a sequence
    8'hC0, 8'h80,                      // overlong
    8'hED, 8'hA0, 8'h80,               // surrogate
    8'hF4, 8'h90, 8'h80, 8'h80,        // above the scalar range
    8'h00                              // end of text
  };

  utf8_stream_decoder_unit dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_word  (in_if),
    .out_word (out_if),
    .cfg_word (cfg_if)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("utf8_stream_decoder_unit: mismatch");
      $finish;
    end
  end

  // output monitor
  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready)
      board.check_word(out_if.code_point, out_if.is_error, out_if.last_of_run);
  end

  function automatic int unsigned draw_wait(input int unsigned max_wait);
    return (max_wait == 0) ? 0 : $urandom_range(max_wait, 0);
  endfunction

  // result side backpressure, one draw per word
  initial begin
    int unsigned stall;
    out_if.ready = 1'b0;
    forever begin
      stall = draw_wait(out_gap_max);
      @(negedge clk);
      if (stall > 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk); while (!(out_if.valid && rst_n));
    end
  end

  // send one byte; valid stays high after the word moves
  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    gap = draw_wait(in_gap_max);
    @(negedge clk);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_if.valid     <= 1'b1;
    in_if.text_byte <= b;
    do @(posedge clk); while (!in_if.ready);
    board.take_byte(b);
    bytes_sent++;
  endtask

  task automatic stop_bytes();
    @(negedge clk);
    in_if.valid <= 1'b0;
  endtask

  // wait until every expected word has arrived, then let the front settle
  task automatic drain();
    while (board.expected_cps.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_replacement(input logic [CP_W-1:0] code);
    @(negedge clk);
    cfg_if.valid            <= 1'b1;
    cfg_if.replacement_code <= code;
    do @(posedge clk); while (!cfg_if.ready);
    board.set_replacement(code);
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  // utf-8 bit layout for any value and length, valid or not
  function automatic void encode(input logic [CP_W-1:0] cp, input int unsigned len,
                                 ref logic [7:0] seq[$]);
    case (len)
      2: begin
        seq.insert(seq.size(), {3'b110, cp[10:6]});
        seq.insert(seq.size(), {2'b10, cp[5:0]});
      end
      3: begin
        seq.insert(seq.size(), {4'b1110, cp[15:12]});
        seq.insert(seq.size(), {2'b10, cp[11:6]});
        seq.insert(seq.size(), {2'b10, cp[5:0]});
      end
      default: begin
        seq.insert(seq.size(), {5'b11110, cp[20:18]});
        seq.insert(seq.size(), {2'b10, cp[17:12]});
        seq.insert(seq.size(), {2'b10, cp[11:6]});
        seq.insert(seq.size(), {2'b10, cp[5:0]});
      end
    endcase
  endfunction

  function automatic logic [CP_W-1:0] valid_value(input int unsigned len);
    logic [CP_W-1:0] cp;
    case (len)
      2: cp = CP_W'($urandom_range(21'h7FF, 21'h80));
      3: begin
        cp = CP_W'($urandom_range(21'hFFFF, 21'h800));
        if (cp >= SURR_LO && cp <= SURR_HI)
          cp = cp - 21'h1000;
      end
      default: cp = CP_W'($urandom_range(CP_MAX, MIN_LEN4));
    endcase
    return cp;
  endfunction

  // mostly well-formed text, with a share of broken sequences and noise
  task automatic send_random_sequence();
    logic [7:0]      seq[$];
    logic [CP_W-1:0] cp;
    int unsigned     pick;
    int unsigned     len;
    int unsigned     cut;
    pick = $urandom_range(99, 0);
    len  = $urandom_range(4, 2);
    if (pick < 30) begin
      seq.insert(seq.size(), 8'($urandom_range(8'h7F, 8'h01)));
    end else if (pick < 45) begin
      encode(valid_value(2), 2, seq);
    end else if (pick < 60) begin
      encode(valid_value(3), 3, seq);
    end else if (pick < 74) begin
      encode(valid_value(4), 4, seq);
    end else if (pick < 79) begin
      // overlong
      cp = (len == 2) ? CP_W'($urandom_range(21'h7F, 0)) :
           (len == 3) ? CP_W'($urandom_range(21'h7FF, 0)) :
                        CP_W'($urandom_range(21'hFFFF, 0));
      encode(cp, len, seq);
    end else if (pick < 82) begin
      encode(CP_W'($urandom_range(SURR_HI, SURR_LO)), 3, seq);
    end else if (pick < 85) begin
      encode(CP_W'($urandom_range(21'h1FFFFF, 21'h110000)), 4, seq);
    end else if (pick < 92) begin
      // truncated sequence; the next byte breaks it
      encode(valid_value(len), len, seq);
      cut = $urandom_range(len - 1, 1);
      repeat (cut) void'(seq.pop_back());
    end else if (pick < 97) begin
      if ($urandom_range(1, 0))
        seq.insert(seq.size(), 8'($urandom_range(8'hBF, 8'h80)));
      else
        seq.insert(seq.size(), 8'($urandom_range(8'hFF, 8'hF8)));
    end else begin
      seq.insert(seq.size(), 8'h00);
    end
    foreach (seq[i]) send_byte(seq[i]);
  endtask

  function automatic int unsigned pick_gap_max();
    case ($urandom_range(2, 0))
      0: return 0;
      1: return 3;
      default: return 14;
    endcase
  endfunction

  // main sequence
  initial begin
    logic [CP_W-1:0] codes[4];
    int unsigned     target;
    int unsigned     next_shuffle;
    board                   = new();
    rst_n                   = 1'b0;
    in_if.valid             = 1'b0;
    in_if.text_byte         = '0;
    cfg_if.valid            = 1'b0;
    cfg_if.replacement_code = '0;
    in_gap_max              = 14;
    out_gap_max             = 14;
    bytes_sent              = 0;
    codes[0] = '0;
    codes[1] = CP_MAX;
    codes[2] = CP_W'($urandom_range(CP_MAX, 0));
    codes[3] = REPLACEMENT_RST;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed bytes under the reset replacement code
    foreach (directed_bytes[i]) send_byte(directed_bytes[i]);
    stop_bytes();
    drain();

    // random text under each replacement code
    foreach (codes[p]) begin
      write_replacement(codes[p]);
      target       = bytes_sent + BYTES_PER_PHASE;
      next_shuffle = bytes_sent;
      while (bytes_sent < target) begin
        if (bytes_sent >= next_shuffle) begin
          in_gap_max   = pick_gap_max();
          out_gap_max  = pick_gap_max();
          next_shuffle = bytes_sent + 30;
        end
        send_random_sequence();
      end
      stop_bytes();
      drain();
    end

    if (board.errors == 0)
      $display("utf8_stream_decoder_unit: match");
    else
      $display("utf8_stream_decoder_unit: mismatch");
    $finish;
  end

endmodule
